// ----- rtl/hfd_pkg.sv -----
// shared types, constants and crc helper for the sensor frame decoder
package hfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef logic [2:0] pos_t;

  localparam pos_t POS_HUM_HI  = 3'd2;
  localparam pos_t POS_HUM_LO  = 3'd3;
  localparam pos_t POS_TEMP_HI = 3'd4;
  localparam pos_t POS_TEMP_LO = 3'd5;
  localparam pos_t POS_CRC_LO  = 3'd6;
  localparam pos_t POS_CRC_HI  = 3'd7;

  // payload handed from the frame tracker to the result stage
  typedef struct packed {
    logic [15:0] humidity;
    logic [15:0] temp_raw;
    logic        crc_ok;
  } frame_res_t;

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/hfd_frame_track.sv -----
// frame position, running crc and field capture
module hfd_frame_track
  import hfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       res_fire,
  output frame_res_t res
);

  pos_t        pos_r, pos_nxt, pos;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic [15:0] hum_r, hum_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  assign pos      = frame_start ? '0 : pos_r;
  assign crc_base = (pos == '0) ? CRC_INIT : crc_r;

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hum_nxt    = hum_r;
    temp_nxt   = temp_r;
    crc_lo_nxt = crc_lo_r;
    if (take) begin
      pos_nxt = pos + 3'd1;
      if (pos < POS_CRC_LO) begin
        crc_nxt = crc_byte(crc_base, rx_byte);
      end
      case (pos)
        POS_HUM_HI:  hum_nxt    = {rx_byte, hum_r[7:0]};
        POS_HUM_LO:  hum_nxt    = {hum_r[15:8], rx_byte};
        POS_TEMP_HI: temp_nxt   = {rx_byte, temp_r[7:0]};
        POS_TEMP_LO: temp_nxt   = {temp_r[15:8], rx_byte};
        POS_CRC_LO:  crc_lo_nxt = rx_byte;
        default: ;
      endcase
    end
  end

  assign res_fire     = take && (pos == POS_CRC_HI);
  assign res.humidity = hum_r;
  assign res.temp_raw = temp_r;
  assign res.crc_ok   = (crc_r == {rx_byte, crc_lo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      hum_r    <= '0;
      temp_r   <= '0;
      crc_lo_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hum_r    <= hum_nxt;
      temp_r   <= temp_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    take && frame_start |=> pos_r == 3'd1)
    else $error("start flag did not move position to byte 1");

  a_fire_take: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> take && !frame_start)
    else $error("result raised without a byte 7 request");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(crc_r) && $stable(pos_r))
    else $error("frame state moved without a request");

endmodule

// ----- rtl/hfd_out_stage.sv -----
// result register with sign-magnitude to two's complement conversion
module hfd_out_stage
  import hfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  frame_res_t  res,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        can_take,
  output logic [15:0] out_humidity_tenths,
  output logic signed [15:0] out_temperature_tenths,
  output logic        out_crc_ok
);

  logic        valid_r, valid_nxt;
  logic [15:0] hum_r;
  logic [15:0] temp_r;
  logic        ok_r;
  logic [15:0] mag;
  logic [15:0] temp_tc;

  // negative zero folds to zero through the negate
  assign mag     = {1'b0, res.temp_raw[14:0]};
  assign temp_tc = res.temp_raw[15] ? (16'd0 - mag) : mag;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hum_r  <= res.humidity;
      temp_r <= temp_tc;
      ok_r   <= res.crc_ok;
    end
  end

  assign out_valid              = valid_r;
  assign out_humidity_tenths    = hum_r;
  assign out_temperature_tenths = $signed(temp_r);
  assign out_crc_ok             = ok_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && valid_r && !out_ready))
    else $error("pending result overwritten");

  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> temp_r != 16'h8000)
    else $error("temperature outside sign-magnitude range");

endmodule

// ----- rtl/humidity_temp_frame_decoder_core.sv -----
// top level of the crc-checked humidity and temperature frame decoder
// latency: a result is presented the cycle after byte 7 of a frame is accepted
// throughput: one byte per cycle while in_ready is high; the crc byte update and
// field capture sit between the input port and the frame registers, the result register follows
// ready drops only while a result waits and out_ready is low
// reset (rst_n, synchronous): position 0, crc 0xffff, captures zero, no result
module humidity_temp_frame_decoder_core
  import hfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_humidity_tenths,
  output logic signed [15:0] out_temperature_tenths,
  output logic        out_crc_ok
);

  logic       take;
  logic       res_fire;
  logic       can_take;
  frame_res_t res;

  assign in_ready = can_take;
  assign take     = in_valid && in_ready;

  hfd_frame_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .res_fire    (res_fire),
    .res         (res)
  );

  hfd_out_stage u_out (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .load                   (res_fire),
    .res                    (res),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .can_take               (can_take),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_crc_ok             (out_crc_ok)
  );

  a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !out_valid || out_ready)
    else $error("byte 7 request taken with no room for its result");

endmodule

// ----- tb/humidity_temp_frame_decoder_core_tb.sv -----
// self-checking testbench for the crc-checked humidity and temperature frame decoder
module humidity_temp_frame_decoder_core_tb;
  import hfd_pkg::*;

  localparam pos_t POS_FIRST = 3'd0;
  localparam int RANDOM_BYTES_PER_PHASE = 225;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_request_t;

  typedef struct {
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
    logic               crc_ok;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_humidity_tenths;
  logic signed [15:0] out_temperature_tenths;
  logic out_crc_ok;

  rx_request_t rx_queue[$];
  reading_t    expected_readings[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // decoder state as the testbench sees it
  pos_t        frame_pos = POS_FIRST;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] humidity_cap = '0;
  logic [15:0] temp_cap = '0;
  logic [7:0]  crc_low_cap = '0;

  // position of the next generated byte, used only to decide start flags
  pos_t gen_pos = POS_FIRST;

  humidity_temp_frame_decoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_humidity_tenths(out_humidity_tenths),
    .out_temperature_tenths(out_temperature_tenths),
    .out_crc_ok(out_crc_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bit-serial form of the modbus crc, one data bit shifted in at a time
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic decode_frame_byte(input logic [7:0] b, input logic start);
    pos_t p;
    logic [15:0] mag;
    reading_t r;
    p = start ? POS_FIRST : frame_pos;
    if (p == POS_FIRST) begin
      crc_acc = CRC_INIT;
    end
    if (p < POS_CRC_LO) begin
      crc_acc = modbus_crc_step(crc_acc, b);
    end
    case (p)
      POS_HUM_HI: humidity_cap[15:8] = b;
      POS_HUM_LO: humidity_cap[7:0] = b;
      POS_TEMP_HI: temp_cap[15:8] = b;
      POS_TEMP_LO: temp_cap[7:0] = b;
      POS_CRC_LO: crc_low_cap = b;
      POS_CRC_HI: begin
        // sign-magnitude to two's complement, negative zero folds to zero
        mag = {1'b0, temp_cap[14:0]};
        r.humidity = humidity_cap;
        r.temperature = temp_cap[15] ? -mag : mag;
        r.crc_ok = (crc_acc == {b, crc_low_cap});
        expected_readings.push_back(r);
      end
      default: ;
    endcase
    frame_pos = p + 3'd1;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_request_t q;
    q.rx_byte = b;
    q.frame_start = start;
    rx_queue.push_back(q);
    gen_pos = (start ? POS_FIRST : gen_pos) + 3'd1;
  endtask

  task automatic queue_frame(input logic [15:0] hum, input logic [15:0] temp,
                             input logic [7:0] b0, input logic [7:0] b1,
                             input bit good_crc, input bit use_start);
    logic [15:0] crc;
    logic [7:0] body[6];
    body = '{b0, b1, hum[15:8], hum[7:0], temp[15:8], temp[7:0]};
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = modbus_crc_step(crc, body[i]);
    end
    if (!good_crc) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    // without a start flag the frame only lines up if the stream sits at byte 0
    queue_byte(body[0], use_start || gen_pos != POS_FIRST);
    for (int i = 1; i < 6; i++) begin
      queue_byte(body[i], 1'b0);
    end
    queue_byte(crc[7:0], 1'b0);
    queue_byte(crc[15:8], 1'b0);
  endtask

  // sampled on the falling edge so the driver and monitor have settled
  task automatic wait_until_drained();
    while (rx_queue.size() != 0 || in_valid || expected_readings.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver
  always @(posedge clk) begin : request_driver
    rx_request_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_frame_byte(in_rx_byte, in_frame_start);
      end
      if (!in_valid || in_ready) begin
        if (rx_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          q = rx_queue.pop_front();
          in_rx_byte <= q.rx_byte;
          in_frame_start <= q.frame_start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : reading_monitor
    reading_t r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result hum %h temp %0d ok %b", $time,
                 out_humidity_tenths, out_temperature_tenths, out_crc_ok);
        mismatch_count++;
      end else begin
        r = expected_readings.pop_front();
        if (out_humidity_tenths !== r.humidity) begin
          $display("%0t: humidity expected %h got %h", $time, r.humidity, out_humidity_tenths);
          mismatch_count++;
        end
        if (out_temperature_tenths !== r.temperature) begin
          $display("%0t: temperature expected %0d got %0d", $time, r.temperature,
                   out_temperature_tenths);
          mismatch_count++;
        end
        if (out_crc_ok !== r.crc_ok) begin
          $display("%0t: crc_ok expected %b got %b", $time, r.crc_ok, out_crc_ok);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("humidity_temp_frame_decoder_core_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned send_idle[4];
    int unsigned recv_stall[4];
    int kind;
    int n;
    logic [15:0] temp;
    send_idle = '{0, 77, 0, 20};
    recv_stall = '{0, 0, 77, 20};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, mid-frame restart with negative zero, frame without start flag
    queue_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 1'b1, 1'b1);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_frame(16'h0000, 16'h8000, 8'h00, 8'hFF, 1'b1, 1'b1);
    queue_frame(16'h1234, 16'h7FFF, 8'h55, 8'hAA, 1'b0, 1'b0);
    // hold the sender back until every result is home
    wait_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = send_idle[ph];
      receiver_stall_pct = recv_stall[ph];
      n = 0;
      while (n < RANDOM_BYTES_PER_PHASE) begin
        kind = $urandom_range(99);
        case ($urandom_range(7))
          0: temp = 16'h8000;
          1: temp = 16'h0000;
          default: temp = 16'($urandom());
        endcase
        if (kind < 70) begin
          queue_frame(16'($urandom()), temp, 8'($urandom()), 8'($urandom()), 1'b1,
                      $urandom_range(1) == 1);
          n += 8;
        end else if (kind < 80) begin
          queue_frame(16'($urandom()), temp, 8'($urandom()), 8'($urandom()), 1'b0,
                      $urandom_range(1) == 1);
          n += 8;
        end else if (kind < 90) begin
          // truncated frame, the next start flag drops it
          kind = $urandom_range(1, 7);
          queue_byte(8'($urandom()), 1'b1);
          for (int i = 1; i < kind; i++) begin
            queue_byte(8'($urandom()), 1'b0);
          end
          n += kind;
        end else begin
          kind = $urandom_range(1, 6);
          for (int i = 0; i < kind; i++) begin
            queue_byte(8'($urandom()), $urandom_range(9) == 0);
          end
          n += kind;
        end
      end
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("humidity_temp_frame_decoder_core_tb OK");
    end else begin
      $display("humidity_temp_frame_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hfd_pkg.sv
rtl/hfd_frame_track.sv
rtl/hfd_out_stage.sv
rtl/humidity_temp_frame_decoder_core.sv
tb/humidity_temp_frame_decoder_core_tb.sv
